@@ rtl/core/bqc_pkg.sv @@
// bqc_pkg: shared types, codes and fixed-point helpers of the biquad coefficient calculator
// used by the top level; no dependencies
package bqc_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 40;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd2;

  // filter mode codes; the unused code behaves as peaking
  localparam logic [1:0] MODE_PEAK = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;

  localparam logic signed [DATA_W-1:0] COS_RESET   = 32'sh4000_0000;
  localparam logic [DATA_W-1:0]        ALPHA_RESET = 32'h0100_0000;

  typedef logic signed [63:0] s64_t;

  localparam s64_t ONE_Q30 = 64'sd1 <<< 30;
  localparam logic [63:0] LIM63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam s64_t COEF_MAX = (64'sd1 <<< 39) - 64'sd1;
  localparam s64_t COEF_MIN = -(64'sd1 <<< 39);

  // four 32x32 partial products of a 64x64 product
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = a[31:0] * b[31:0];
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    p.hh = a[63:32] * b[63:32];
    return p;
  endfunction

  function automatic logic [127:0] mul_sum(input pp_t p);
    return {p.hh, 64'b0} + {32'b0, p.lh, 32'b0} + {32'b0, p.hl, 32'b0} + {64'b0, p.ll};
  endfunction

  // magnitude shift, saturation to 2^63-1, then sign
  function automatic s64_t mul_fin(input logic [127:0] p, input logic neg,
                                   input int unsigned sh);
    logic [127:0] q;
    logic [63:0]  m;
    q = p >> sh;
    if (q > {64'b0, LIM63}) m = LIM63;
    else m = q[63:0];
    return neg ? -s64_t'(m) : s64_t'(m);
  endfunction

  function automatic logic [63:0] mag(input s64_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [COEF_W-1:0] clamp(input s64_t c);
    logic [COEF_W-1:0] r;
    if (c > COEF_MAX) r = COEF_MAX[COEF_W-1:0];
    else if (c < COEF_MIN) r = COEF_MIN[COEF_W-1:0];
    else r = c[COEF_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/bqc_isqrt.sv @@
// bqc_isqrt: pipelined integer square root, one root bit per register stage
// standalone; carries a sideband word alongside each request
module bqc_isqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] x,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic            stg_vld  [RW];
  logic [RW+1:0]   stg_rem  [RW];
  logic [RW-1:0]   stg_root [RW];
  logic [2*RW-1:0] stg_x    [RW];
  logic [SW-1:0]   stg_side [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] x_p;
    logic [SW-1:0]   sd_p;
    logic [RW+3:0]   rem2;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
      assign sd_p   = side_in;
    end else begin : g_next
      assign v_p    = stg_vld[k-1];
      assign rem_p  = stg_rem[k-1];
      assign root_p = stg_root[k-1];
      assign x_p    = stg_x[k-1];
      assign sd_p   = stg_side[k-1];
    end

    assign rem2  = {rem_p, x_p[2*RW-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = ge ? (rem2 - trial) : rem2;

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[k] <= 1'b0;
      end else if (en) begin
        stg_vld[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[k]  <= diff[RW+1:0];
        stg_root[k] <= {root_p[RW-2:0], ge};
        stg_x[k]    <= x_p << 2;
        stg_side[k] <= sd_p;
      end
    end
  end

  assign out_valid = stg_vld[RW-1];
  assign root      = stg_root[RW-1];
  assign side_out  = stg_side[RW-1];

endmodule

@@ rtl/core/bqc_div.sv @@
// bqc_div: pipelined restoring divider, one quotient bit per register stage
// standalone; the caller supplies the leading partial remainder and the low dividend bits
module bqc_div #(
  parameter int DW = 34,
  parameter int QW = 50,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rinit,
  input  logic [QW-1:0] nlo,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic          stg_vld  [QW];
  logic [DW-1:0] stg_rem  [QW];
  logic [DW-1:0] stg_den  [QW];
  logic [QW-1:0] stg_quot [QW];
  logic [QW-1:0] stg_n    [QW];
  logic [SW-1:0] stg_side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_p;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] q_p;
    logic [QW-1:0] n_p;
    logic [SW-1:0] sd_p;
    logic [DW:0]   rem2;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p   = in_valid;
      assign rem_p = rinit;
      assign den_p = den;
      assign q_p   = '0;
      assign n_p   = nlo;
      assign sd_p  = side_in;
    end else begin : g_next
      assign v_p   = stg_vld[k-1];
      assign rem_p = stg_rem[k-1];
      assign den_p = stg_den[k-1];
      assign q_p   = stg_quot[k-1];
      assign n_p   = stg_n[k-1];
      assign sd_p  = stg_side[k-1];
    end

    assign rem2 = {rem_p, n_p[QW-1]};
    assign ge   = rem2 >= {1'b0, den_p};
    assign diff = ge ? (rem2 - {1'b0, den_p}) : rem2;

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[k] <= 1'b0;
      end else if (en) begin
        stg_vld[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[k]  <= diff[DW-1:0];
        stg_den[k]  <= den_p;
        stg_quot[k] <= {q_p[QW-2:0], ge};
        stg_n[k]    <= n_p << 1;
        stg_side[k] <= sd_p;
      end
    end
  end

  assign out_valid = stg_vld[QW-1];
  assign quot      = stg_quot[QW-1];
  assign side_out  = stg_side[QW-1];

endmodule

@@ rtl/core/biquad_eq_coefficient_calc.sv @@
// biquad_eq_coefficient_calc: top level of the peaking / shelf biquad coefficient calculator
// depends on bqc_pkg, bqc_isqrt and bqc_div
//
// One gain request in, one set of normalized coefficients out. The unit is a
// single pipeline of 186 register stages: it takes a new gain every cycle
// unless a stalled result holds it. Most of its stages belong to four
// bit-per-stage digit recurrences: the 32-stage square root of the gain, the
// 30-stage fourth root, the 50-stage alpha/A division, and the 63-stage
// reciprocal of a0, plus three split 64x64 multiply steps. A stalled result
// holds the whole pipeline; nothing is lost or repeated. The configuration
// registers (mode, cos omega, alpha) are read live by the stages from the
// alpha/A division onward, so write them only while the pipeline is empty.
module biquad_eq_coefficient_calc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bqc_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                gain_valid,
  output logic                                gain_stall,
  input  logic [bqc_pkg::DATA_W-1:0]          gain,
  output logic                                coef_valid,
  input  logic                                coef_stall,
  output logic signed [bqc_pkg::COEF_W-1:0]   coef_b0,
  output logic signed [bqc_pkg::COEF_W-1:0]   coef_b1,
  output logic signed [bqc_pkg::COEF_W-1:0]   coef_b2,
  output logic signed [bqc_pkg::COEF_W-1:0]   coef_a1,
  output logic signed [bqc_pkg::COEF_W-1:0]   coef_a2,
  output logic                                bad_gain
);
  import bqc_pkg::*;

  // configuration registers
  logic [1:0]               filter_mode;
  logic signed [DATA_W-1:0] cos_omega;
  logic [DATA_W-1:0]        alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_PEAK;
      cos_omega   <= COS_RESET;
      alpha       <= ALPHA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:  filter_mode <= cfg_data[1:0];
        REG_COS:   cos_omega   <= signed'(cfg_data);
        REG_ALPHA: alpha       <= cfg_data;
        default:   ;
      endcase
    end
  end

  // shelves use the fourth root path, everything else the peaking path
  logic shelf;
  logic low_shelf;
  assign shelf     = (filter_mode == MODE_LOW) || (filter_mode == MODE_HIGH);
  assign low_shelf = filter_mode == MODE_LOW;

  logic [37:0] al;
  s64_t        cosx;
  assign al   = {alpha, 6'b0};
  assign cosx = s64_t'(cos_omega);

  // global advance: the whole pipeline moves unless a result waits on a stall
  logic en;
  assign en         = !coef_valid || !coef_stall;
  assign gain_stall = !en;

  // square root of the gain, A with 28 fraction bits
  logic        sq1_vld;
  logic [31:0] a28_1;
  logic        sq1_bad;

  bqc_isqrt #(.RW(32), .SW(1)) u_sqrt_a (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(gain_valid),
    .x({gain, 32'b0}),
    .side_in(gain == '0),
    .out_valid(sq1_vld),
    .root(a28_1),
    .side_out(sq1_bad)
  );

  // fourth root of the gain, for shelves
  logic        sq2_vld;
  logic [29:0] rt30;
  logic [31:0] a28_2;
  logic        sq2_bad;

  bqc_isqrt #(.RW(30), .SW(33)) u_sqrt_rt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq1_vld),
    .x({a28_1, 28'b0}),
    .side_in({a28_1, sq1_bad}),
    .out_valid(sq2_vld),
    .root(rt30),
    .side_out({a28_2, sq2_bad})
  );

  // peaking alpha / A with 30 fraction bits
  logic        dv_vld;
  logic [49:0] p2q;
  logic [31:0] a28_3;
  logic [29:0] rt30_3;
  logic        dv_bad;

  bqc_div #(.DW(34), .QW(50), .SW(63)) u_div_alpha (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq2_vld),
    .den({a28_2, 2'b00}),
    .rinit({16'b0, al[37:20]}),
    .nlo({al[19:0], 30'b0}),
    .side_in({a28_2, rt30, sq2_bad}),
    .out_valid(dv_vld),
    .quot(p2q),
    .side_out({a28_3, rt30_3, dv_bad})
  );

  // first multiply step: (A+1)cos, (A-1)cos, sqrt(A)alpha, alpha*A
  logic [33:0] av3;
  s64_t        v1_3;
  s64_t        v2_3;
  logic [63:0] m1_a [4];
  logic [63:0] m1_b [4];
  logic        m1_n [4];

  assign av3  = {a28_3, 2'b00};
  assign v1_3 = s64_t'({30'b0, av3}) + ONE_Q30;
  assign v2_3 = s64_t'({30'b0, av3}) - ONE_Q30;

  always_comb begin
    m1_a[0] = mag(v1_3);             m1_b[0] = mag(cosx); m1_n[0] = v1_3[63] ^ cosx[63];
    m1_a[1] = mag(v2_3);             m1_b[1] = mag(cosx); m1_n[1] = v2_3[63] ^ cosx[63];
    m1_a[2] = {32'b0, rt30_3, 2'b00}; m1_b[2] = {26'b0, al}; m1_n[2] = 1'b0;
    m1_a[3] = {26'b0, al};            m1_b[3] = {30'b0, av3}; m1_n[3] = 1'b0;
  end

  logic         s1_vld, s2_vld, s3_vld;
  pp_t          s1_pp   [4];
  logic         s1_neg  [4];
  logic [127:0] s2_prod [4];
  logic         s2_neg  [4];
  s64_t         s3_res  [4];
  logic [33:0]  s1_av, s2_av, s3_av;
  logic [49:0]  s1_p2, s2_p2, s3_p2;
  logic         s1_bad, s2_bad, s3_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= dv_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_pp[i]   <= mul_pp(m1_a[i], m1_b[i]);
        s1_neg[i]  <= m1_n[i];
        s2_prod[i] <= mul_sum(s1_pp[i]);
        s2_neg[i]  <= s1_neg[i];
        s3_res[i]  <= mul_fin(s2_prod[i], s2_neg[i], 30);
      end
      s1_av  <= av3;    s2_av  <= s1_av;  s3_av  <= s2_av;
      s1_p2  <= p2q;    s2_p2  <= s1_p2;  s3_p2  <= s2_p2;
      s1_bad <= dv_bad; s2_bad <= s1_bad; s3_bad <= s2_bad;
    end
  end

  // cookbook sums: denominator, feedback numerators, feed-forward multiplicands
  s64_t v1_c, v2_c, p2_c;
  s64_t c_d, c_a1, c_a2;
  s64_t c_s [3];

  always_comb begin
    v1_c = s64_t'({30'b0, s3_av}) + ONE_Q30;
    v2_c = s64_t'({30'b0, s3_av}) - ONE_Q30;
    p2_c = s64_t'({14'b0, s3_p2});
    if (!shelf) begin
      c_d    = ONE_Q30 + p2_c;
      c_a1   = -(cosx <<< 1);
      c_a2   = ONE_Q30 - p2_c;
      c_s[0] = ONE_Q30 + s3_res[3];
      c_s[1] = -(cosx <<< 1);
      c_s[2] = ONE_Q30 - s3_res[3];
    end else if (low_shelf) begin
      c_d    = v1_c + s3_res[1] + s3_res[2];
      c_a1   = -((v2_c + s3_res[0]) <<< 1);
      c_a2   = v1_c + s3_res[1] - s3_res[2];
      c_s[0] = v1_c - s3_res[1] + s3_res[2];
      c_s[1] = (v2_c - s3_res[0]) <<< 1;
      c_s[2] = v1_c - s3_res[1] - s3_res[2];
    end else begin
      c_d    = v1_c - s3_res[1] + s3_res[2];
      c_a1   = (v2_c - s3_res[0]) <<< 1;
      c_a2   = v1_c - s3_res[1] - s3_res[2];
      c_s[0] = v1_c + s3_res[1] + s3_res[2];
      c_s[1] = -((v2_c + s3_res[0]) <<< 1);
      c_s[2] = v1_c + s3_res[1] - s3_res[2];
    end
  end

  // second multiply step: shelf feed-forward numerators are A times the sums
  logic         s4_vld, s5_vld, s6_vld, s7_vld;
  s64_t         s4_s [3], s5_s [3], s6_s [3];
  pp_t          s5_pp [3];
  logic [127:0] s6_prod [3];
  s64_t         s7_nb [3];
  logic [33:0]  s4_av;
  s64_t         s4_d, s5_d, s6_d, s7_d;
  s64_t         s4_a1, s5_a1, s6_a1, s7_a1;
  s64_t         s4_a2, s5_a2, s6_a2, s7_a2;
  logic         s4_bad, s5_bad, s6_bad, s7_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_s[i]    <= c_s[i];
        s5_pp[i]   <= mul_pp({30'b0, s4_av}, mag(s4_s[i]));
        s5_s[i]    <= s4_s[i];
        s6_prod[i] <= mul_sum(s5_pp[i]);
        s6_s[i]    <= s5_s[i];
        s7_nb[i]   <= shelf ? mul_fin(s6_prod[i], s6_s[i][63], 30) : s6_s[i];
      end
      s4_av  <= s3_av;
      s4_d   <= c_d;    s5_d   <= s4_d;   s6_d   <= s5_d;   s7_d   <= s6_d;
      s4_a1  <= c_a1;   s5_a1  <= s4_a1;  s6_a1  <= s5_a1;  s7_a1  <= s6_a1;
      s4_a2  <= c_a2;   s5_a2  <= s4_a2;  s6_a2  <= s5_a2;  s7_a2  <= s6_a2;
      s4_bad <= s3_bad; s5_bad <= s4_bad; s6_bad <= s5_bad; s7_bad <= s6_bad;
    end
  end

  // reciprocal of |a0| with 50 fraction bits; |a0| at or below 2^17 saturates
  logic [63:0] ur;
  logic        rc_sat_in;
  assign ur        = mag(s7_d);
  assign rc_sat_in = ur <= 64'd131072;

  logic        rc_vld;
  logic [62:0] rc_q;
  s64_t        r_nb0, r_nb1, r_nb2, r_a1, r_a2;
  logic        r_dneg, r_sat, r_bad;

  bqc_div #(.DW(52), .QW(63), .SW(323)) u_div_recip (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s7_vld),
    .den(ur[51:0]),
    .rinit(52'd131072),
    .nlo('0),
    .side_in({s7_nb[0], s7_nb[1], s7_nb[2], s7_a1, s7_a2, s7_d[63], rc_sat_in, s7_bad}),
    .out_valid(rc_vld),
    .quot(rc_q),
    .side_out({r_nb0, r_nb1, r_nb2, r_a1, r_a2, r_dneg, r_sat, r_bad})
  );

  // final multiply step: each numerator times the reciprocal
  logic [63:0] recip;
  s64_t        f_num [5];
  assign recip = r_sat ? LIM63 : {1'b0, rc_q};

  always_comb begin
    f_num[0] = r_nb0;
    f_num[1] = r_nb1;
    f_num[2] = r_nb2;
    f_num[3] = r_a1;
    f_num[4] = r_a2;
  end

  logic         s9_vld, s10_vld, s11_vld;
  pp_t          s9_pp   [5];
  logic         s9_neg  [5];
  logic [127:0] s10_prod [5];
  logic         s10_neg [5];
  s64_t         s11_c   [5];
  logic         s9_dneg, s10_dneg, s11_dneg;
  logic         s9_bad, s10_bad, s11_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
    end else if (en) begin
      s9_vld  <= rc_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 5; i++) begin
        s9_pp[i]    <= mul_pp(mag(f_num[i]), recip);
        s9_neg[i]   <= f_num[i][63];
        s10_prod[i] <= mul_sum(s9_pp[i]);
        s10_neg[i]  <= s9_neg[i];
        s11_c[i]    <= mul_fin(s10_prod[i], s10_neg[i], 50);
      end
      s9_dneg <= r_dneg; s10_dneg <= s9_dneg; s11_dneg <= s10_dneg;
      s9_bad  <= r_bad;  s10_bad  <= s9_bad;  s11_bad  <= s10_bad;
    end
  end

  // sign of a0, saturation to 40 bits, zero gain forces zero coefficients
  logic [COEF_W-1:0] o_coef [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (s11_bad) o_coef[i] = '0;
      else o_coef[i] = clamp(s11_dneg ? -s11_c[i] : s11_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (en) begin
      coef_valid <= s11_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_b0  <= signed'(o_coef[0]);
      coef_b1  <= signed'(o_coef[1]);
      coef_b2  <= signed'(o_coef[2]);
      coef_a1  <= signed'(o_coef[3]);
      coef_a2  <= signed'(o_coef[4]);
      bad_gain <= s11_bad;
    end
  end

endmodule

@@ verif/testbench.sv @@
// testbench: self-checking bench for biquad_eq_coefficient_calc
// depends on bqc_pkg and the rtl of the block; predicts coefficients per gain request
module testbench;
  import bqc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam s64_t UNITY = 64'sd1 <<< 30;

  typedef struct {
    logic [COEF_W-1:0] b0, b1, b2, a1, a2;
    logic              bad;
  } coef_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic gain_valid = 1'b0;
  logic gain_stall;
  logic [DATA_W-1:0] gain = '0;
  logic coef_valid;
  logic coef_stall = 1'b0;
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic bad_gain;

  // local copy of the configuration registers
  logic [1:0]        mode_q = MODE_PEAK;
  s64_t              cos_q = 64'sd1 <<< 30;
  logic [63:0]       alpha_q = 64'h0100_0000;

  coef_set_t pending_coefs[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  biquad_eq_coefficient_calc dut (.*);

  always #5 clk = ~clk;

  // ---------------- fixed-point predictor ----------------

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // (a*b) >> s on magnitudes, saturated to 2^63-1
  function automatic logic [63:0] umul_shr(input logic [63:0] a, input logic [63:0] b,
                                           input int s);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> s;
    return (p > {64'b0, SAT63}) ? SAT63 : p[63:0];
  endfunction

  function automatic logic [63:0] abs_u(input s64_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // product truncated toward zero, sign restored afterwards
  function automatic s64_t smul_shr(input s64_t a, input s64_t b, input int s);
    logic [63:0] m;
    m = umul_shr(abs_u(a), abs_u(b), s);
    return (a[63] != b[63]) ? -s64_t'(m) : s64_t'(m);
  endfunction

  // floor(num * 2^s / den), saturated; zero divisor saturates
  function automatic logic [63:0] udiv_shr(input logic [63:0] num, input logic [63:0] den,
                                           input int s);
    logic [159:0] q;
    if (den == 0) return SAT63;
    q = ({96'b0, num} << s) / {96'b0, den};
    return (q > {96'b0, SAT63}) ? SAT63 : q[63:0];
  endfunction

  function automatic logic [COEF_W-1:0] normalize(input s64_t num, input logic [63:0] recip,
                                                  input logic dneg);
    s64_t c;
    c = smul_shr(num, s64_t'(recip), 50);
    if (dneg) c = -c;
    if (c > COEF_MAX) c = COEF_MAX;
    if (c < COEF_MIN) c = COEF_MIN;
    return c[COEF_W-1:0];
  endfunction

  function automatic coef_set_t eq_coefs(input logic [DATA_W-1:0] g);
    coef_set_t e;
    logic [63:0] a28, ua, recip;
    s64_t av, al, den, nb0, nb1, nb2, na1, na2, rt, v1, v2, v3, v4, v5, p1, p2;
    e = '{default: '0};
    if (g == 0) begin
      e.bad = 1'b1;
      return e;
    end
    a28 = root_floor({g, 32'b0});
    ua = a28 << 2;
    av = s64_t'(ua);
    al = s64_t'(alpha_q << 6);
    if (mode_q == MODE_LOW || mode_q == MODE_HIGH) begin
      rt = s64_t'(root_floor(a28 << 28) << 2);
      v1 = av + UNITY;
      v2 = av - UNITY;
      v3 = smul_shr(v1, cos_q, 30);
      v4 = smul_shr(v2, cos_q, 30);
      v5 = smul_shr(rt, al, 30);
      if (mode_q == MODE_LOW) begin
        den = v1 + v4 + v5;
        na1 = -2 * (v2 + v3);
        na2 = v1 + v4 - v5;
        nb0 = smul_shr(av, v1 - v4 + v5, 30);
        nb1 = smul_shr(av, 2 * (v2 - v3), 30);
        nb2 = smul_shr(av, v1 - v4 - v5, 30);
      end else begin
        den = v1 - v4 + v5;
        na1 = 2 * (v2 - v3);
        na2 = v1 - v4 - v5;
        nb0 = smul_shr(av, v1 + v4 + v5, 30);
        nb1 = smul_shr(av, -2 * (v2 + v3), 30);
        nb2 = smul_shr(av, v1 + v4 - v5, 30);
      end
    end else begin
      // peaking, and the spare mode code
      p1 = smul_shr(al, av, 30);
      p2 = s64_t'(udiv_shr(64'(al), ua, 30));
      den = UNITY + p2;
      na1 = -2 * cos_q;
      na2 = UNITY - p2;
      nb0 = UNITY + p1;
      nb1 = na1;
      nb2 = UNITY - p1;
    end
    recip = (abs_u(den) == 0) ? SAT63 : udiv_shr(64'd1, abs_u(den), 80);
    e.b0 = normalize(nb0, recip, den[63]);
    e.b1 = normalize(nb1, recip, den[63]);
    e.b2 = normalize(nb2, recip, den[63]);
    e.a1 = normalize(na1, recip, den[63]);
    e.a2 = normalize(na2, recip, den[63]);
    return e;
  endfunction

  // ---------------- driving ----------------

  // receiver side: random stalls, or a counted long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      coef_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      coef_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one gain request; prediction queued once the block accepts it
  task automatic send_gain(input logic [DATA_W-1:0] g);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      gain_valid = 1'b0;
      gain = $urandom;
      @(negedge clk);
    end
    gain_valid = 1'b1;
    gain = g;
    do @(posedge clk); while (gain_stall);
    pending_coefs.push_back(eq_coefs(g));
  endtask

  task automatic drain;
    @(negedge clk);
    gain_valid = 1'b0;
    wait (pending_coefs.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_MODE:  mode_q = val[1:0];
      REG_COS:   cos_q = s64_t'($signed(val));
      REG_ALPHA: alpha_q = {32'b0, val};
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // only while the pipeline is empty
  task automatic set_filter(input logic [1:0] m, input logic [31:0] c, input logic [31:0] a);
    drain();
    write_reg(REG_MODE, {30'b0, m});
    write_reg(REG_COS, c);
    write_reg(REG_ALPHA, a);
  endtask

  function automatic logic [31:0] pick_gain;
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom_range(255);
      2: return 32'h0100_0000 + $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      3: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_cos;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hC000_0000;      // -1.0
      3: return 32'h4000_0000;      // 1.0
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_alpha;
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h0200_0000);
      default: return $urandom;
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed;
    // every mode at the gain extremes and unity, with the reset cos and alpha
    for (int m = 0; m < 4; m++) begin
      set_filter(2'(m), COS_RESET, ALPHA_RESET);
      send_gain(32'h0);
      send_gain(32'h1);
      send_gain(32'h0100_0000);
      send_gain(32'hFFFF_FFFF);
    end
    // cos beyond +-1 can zero or flip the shelf denominator
    set_filter(MODE_LOW, 32'h8000_0000, 32'h0);
    send_gain(32'h0100_0000);
    send_gain(32'h0400_0000);
    set_filter(MODE_HIGH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_gain(32'h0100_0000);
    send_gain(32'h8000_0000);
    set_filter(MODE_PEAK, 32'h0, 32'hFFFF_FFFF);
    send_gain(32'h0000_0100);
    // unmapped register index leaves everything as it was
    drain();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_gain(32'h0200_0000);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) set_filter(2'($urandom_range(3)), pick_cos(), pick_alpha());
      send_gain(pick_gain());
    end
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // output held long enough for the pipeline to fill and push back on gain
  task automatic test_backpressure;
    set_filter(MODE_HIGH, $urandom, $urandom_range(32'h0400_0000));
    hold_left = 400;
    for (int i = 0; i < 250; i++) send_gain($urandom);
    drain();
  endtask

  // ---------------- checking ----------------

  task automatic report(input string what, input logic [COEF_W-1:0] got,
                        input logic [COEF_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    coef_set_t e;
    if (!rst && coef_valid && !coef_stall) begin
      if (pending_coefs.size() == 0) begin
        report("unexpected result", coef_b0, '0);
      end else begin
        e = pending_coefs.pop_front();
        if (coef_b0 !== e.b0) report("b0", coef_b0, e.b0);
        if (coef_b1 !== e.b1) report("b1", coef_b1, e.b1);
        if (coef_b2 !== e.b2) report("b2", coef_b2, e.b2);
        if (coef_a1 !== e.a1) report("a1", coef_a1, e.a1);
        if (coef_a2 !== e.a2) report("a2", coef_a2, e.a2);
        if (bad_gain !== e.bad) report("bad_gain", 40'(bad_gain), 40'(e.bad));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(320, 0, 0);
    test_random(320, 78, 0);
    test_random(320, 0, 78);
    test_random(320, 33, 33);
    test_backpressure();
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bqc_pkg.sv
rtl/core/bqc_isqrt.sv
rtl/core/bqc_div.sv
rtl/core/biquad_eq_coefficient_calc.sv
verif/testbench.sv
